// ----- rtl/core/bmhpq_pkg.sv -----
package bmhpq_pkg;

    localparam int DEPTH   = 4096;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int CHILD_W = ADDR_W + 2;
    localparam int KEY_W   = 32;
    localparam int COUNT_W = 13;

    typedef logic signed [KEY_W-1:0] key_t;

    typedef enum logic {
        ACT_INSERT  = 1'b0,
        ACT_EXTRACT = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        PICK_BASE = 2'd0,
        PICK_A    = 2'd1,
        PICK_B    = 2'd2
    } pick_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_SU_RD,
        ST_SU_CMP,
        ST_EX_LAST,
        ST_SD_RD,
        ST_SD_CMP,
        ST_DONE
    } state_t;

    typedef struct packed {
        action_t action;
        key_t    key;
    } cmd_t;

    typedef struct packed {
        status_t             status;
        key_t                value;
        logic [COUNT_W-1:0]  count;
    } rsp_t;

endpackage

// ----- rtl/core/bmhpq_ram.sv -----
module bmhpq_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr_a,
    input  logic [ADDR_W-1:0] raddr_b,
    output logic [DATA_W-1:0] rdata_a,
    output logic [DATA_W-1:0] rdata_b
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ----- rtl/core/bmhpq_sel.sv -----
module bmhpq_sel (
    input  bmhpq_pkg::key_t  base,
    input  bmhpq_pkg::key_t  cand_a,
    input  logic             a_vld,
    input  bmhpq_pkg::key_t  cand_b,
    input  logic             b_vld,
    output bmhpq_pkg::pick_t pick
);

    bmhpq_pkg::key_t win;

    // strict compares: equal keys keep the earlier pick
    always_comb
    begin
        pick = bmhpq_pkg::PICK_BASE;
        win  = base;
        if (a_vld && (win < cand_a))
        begin
            pick = bmhpq_pkg::PICK_A;
            win  = cand_a;
        end
        if (b_vld && (win < cand_b))
        begin
            pick = bmhpq_pkg::PICK_B;
        end
    end

endmodule

// ----- rtl/core/binary_max_heap_priority_queue_unit.sv -----
// Binary max-heap priority queue of signed 32-bit keys, DEPTH entries in one
// RAM with one write and two read ports. Each request (insert or extract max)
// gives one response: status, the removed maximum or the maximum after the
// insert, and the count. The unit takes one request at a time; cmd_ready is
// high only while idle, and a finished response waits in an output register
// so the next request can enter before it is taken. An insert moves its key up
// from the new last entry toward the root; an extract takes the last entry and
// moves it down from the root toward the leaves. Each level the key moves is
// a RAM read state and a compare-and-write state through the shared compare
// unit. Refused inserts, extracts on an empty heap and extracts of the last
// key go straight from the start state to the done state. A response that
// finds the previous one still waiting for rsp_ready holds the unit until that
// one is taken.
// The RAM needs no clearing after reset: only entries below the count are used.
module binary_max_heap_priority_queue_unit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_ready,
    input  bmhpq_pkg::cmd_t cmd,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output bmhpq_pkg::rsp_t rsp
);

    localparam int ADDR_W  = bmhpq_pkg::ADDR_W;
    localparam int CNT_W   = bmhpq_pkg::CNT_W;
    localparam int CHILD_W = bmhpq_pkg::CHILD_W;

    bmhpq_pkg::state_t    state_reg, state_next;
    logic [ADDR_W-1:0]    i_reg, i_next;
    bmhpq_pkg::key_t      x_reg, x_next;
    bmhpq_pkg::action_t   act_reg, act_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    bmhpq_pkg::status_t   status_reg, status_next;
    bmhpq_pkg::key_t      val_reg, val_next;
    bmhpq_pkg::key_t      root_reg;
    bmhpq_pkg::rsp_t      rsp_reg, rsp_next;
    logic                 rsp_valid_reg, rsp_valid_next;

    logic                 we;
    logic [ADDR_W-1:0]    waddr;
    bmhpq_pkg::key_t      wdata;
    logic [ADDR_W-1:0]    raddr_a, raddr_b;
    logic [bmhpq_pkg::KEY_W-1:0] rdata_a, rdata_b;

    logic [ADDR_W-1:0]    parent;
    logic [CHILD_W-1:0]   l_idx, r_idx, cnt_ext;
    logic                 r_vld;

    bmhpq_pkg::key_t      sel_base, sel_a;
    logic                 sel_b_vld;
    bmhpq_pkg::pick_t     pick;

    bmhpq_ram #(
        .DATA_W (bmhpq_pkg::KEY_W),
        .DEPTH  (bmhpq_pkg::DEPTH)
    ) u_ram (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    assign parent  = (i_reg - 1'b1) >> 1;
    assign l_idx   = (CHILD_W'(i_reg) << 1) + CHILD_W'(1);
    assign r_idx   = (CHILD_W'(i_reg) << 1) + CHILD_W'(2);
    assign cnt_ext = CHILD_W'(count_reg);
    assign r_vld   = (r_idx < cnt_ext);

    // sift-up: parent is base, moving key is candidate
    // sift-down: moving key is base, children are candidates
    assign sel_base  = (state_reg == bmhpq_pkg::ST_SU_CMP) ? bmhpq_pkg::key_t'(rdata_a) : x_reg;
    assign sel_a     = (state_reg == bmhpq_pkg::ST_SU_CMP) ? x_reg : bmhpq_pkg::key_t'(rdata_a);
    assign sel_b_vld = (state_reg == bmhpq_pkg::ST_SD_CMP) && r_vld;

    bmhpq_sel u_sel (
        .base   (sel_base),
        .cand_a (sel_a),
        .a_vld  (1'b1),
        .cand_b (bmhpq_pkg::key_t'(rdata_b)),
        .b_vld  (sel_b_vld),
        .pick   (pick)
    );

    assign cmd_ready = (state_reg == bmhpq_pkg::ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        i_next         = i_reg;
        x_next         = x_reg;
        act_next       = act_reg;
        count_next     = count_reg;
        status_next    = status_reg;
        val_next       = val_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        we             = 1'b0;
        waddr          = i_reg;
        wdata          = x_reg;
        raddr_a        = '0;
        raddr_b        = '0;

        unique case (state_reg)
            bmhpq_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    act_next   = cmd.action;
                    x_next     = cmd.key;
                    state_next = bmhpq_pkg::ST_START;
                end
            end
            bmhpq_pkg::ST_START:
            begin
                status_next = bmhpq_pkg::STATUS_OK;
                if (act_reg == bmhpq_pkg::ACT_INSERT)
                begin
                    if (count_reg == CNT_W'(bmhpq_pkg::DEPTH))
                    begin
                        status_next = bmhpq_pkg::STATUS_FULL;
                        state_next  = bmhpq_pkg::ST_DONE;
                    end
                    else
                    begin
                        i_next     = ADDR_W'(count_reg);
                        count_next = count_reg + 1'b1;
                        state_next = bmhpq_pkg::ST_SU_RD;
                    end
                end
                else
                begin
                    if (count_reg == '0)
                    begin
                        status_next = bmhpq_pkg::STATUS_EMPTY;
                        state_next  = bmhpq_pkg::ST_DONE;
                    end
                    else
                    begin
                        val_next   = root_reg;
                        count_next = count_reg - 1'b1;
                        raddr_a    = ADDR_W'(count_reg - 1'b1);
                        if (count_reg == CNT_W'(1))
                        begin
                            state_next = bmhpq_pkg::ST_DONE;
                        end
                        else
                        begin
                            state_next = bmhpq_pkg::ST_EX_LAST;
                        end
                    end
                end
            end
            bmhpq_pkg::ST_EX_LAST:
            begin
                x_next     = bmhpq_pkg::key_t'(rdata_a);
                i_next     = '0;
                state_next = bmhpq_pkg::ST_SD_RD;
            end
            bmhpq_pkg::ST_SD_RD:
            begin
                if (l_idx >= cnt_ext)
                begin
                    we         = 1'b1;
                    state_next = bmhpq_pkg::ST_DONE;
                end
                else
                begin
                    raddr_a    = l_idx[ADDR_W-1:0];
                    raddr_b    = r_idx[ADDR_W-1:0];
                    state_next = bmhpq_pkg::ST_SD_CMP;
                end
            end
            bmhpq_pkg::ST_SD_CMP:
            begin
                we = 1'b1;
                unique case (pick)
                    bmhpq_pkg::PICK_A:
                    begin
                        wdata      = bmhpq_pkg::key_t'(rdata_a);
                        i_next     = l_idx[ADDR_W-1:0];
                        state_next = bmhpq_pkg::ST_SD_RD;
                    end
                    bmhpq_pkg::PICK_B:
                    begin
                        wdata      = bmhpq_pkg::key_t'(rdata_b);
                        i_next     = r_idx[ADDR_W-1:0];
                        state_next = bmhpq_pkg::ST_SD_RD;
                    end
                    default:
                    begin
                        state_next = bmhpq_pkg::ST_DONE;
                    end
                endcase
            end
            bmhpq_pkg::ST_SU_RD:
            begin
                if (i_reg == '0)
                begin
                    we         = 1'b1;
                    state_next = bmhpq_pkg::ST_DONE;
                end
                else
                begin
                    raddr_a    = parent;
                    state_next = bmhpq_pkg::ST_SU_CMP;
                end
            end
            bmhpq_pkg::ST_SU_CMP:
            begin
                we = 1'b1;
                if (pick == bmhpq_pkg::PICK_A)
                begin
                    wdata      = bmhpq_pkg::key_t'(rdata_a);
                    i_next     = parent;
                    state_next = bmhpq_pkg::ST_SU_RD;
                end
                else
                begin
                    state_next = bmhpq_pkg::ST_DONE;
                end
            end
            bmhpq_pkg::ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next.status = status_reg;
                    rsp_next.count  = bmhpq_pkg::COUNT_W'(count_reg);
                    if (status_reg != bmhpq_pkg::STATUS_OK)
                    begin
                        rsp_next.value = '0;
                    end
                    else if (act_reg == bmhpq_pkg::ACT_INSERT)
                    begin
                        rsp_next.value = root_reg;
                    end
                    else
                    begin
                        rsp_next.value = val_reg;
                    end
                    state_next = bmhpq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bmhpq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bmhpq_pkg::ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg      <= i_next;
        x_reg      <= x_next;
        act_reg    <= act_next;
        status_reg <= status_next;
        val_reg    <= val_next;
        rsp_reg    <= rsp_next;
        if (we && (waddr == '0))
        begin
            root_reg <= wdata;
        end
    end

endmodule

// ----- rtl/core/bmhpq_chk.sv -----
module bmhpq_chk (
    input logic            clk,
    input logic            rst_n,
    input logic            cmd_valid,
    input logic            cmd_ready,
    input bmhpq_pkg::cmd_t cmd,
    input logic            rsp_valid,
    input logic            rsp_ready,
    input bmhpq_pkg::rsp_t rsp
);

    localparam logic [bmhpq_pkg::COUNT_W-1:0] FULL_COUNT =
        bmhpq_pkg::COUNT_W'(bmhpq_pkg::DEPTH);

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.count <= FULL_COUNT))
        else $error("response count above capacity");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status == bmhpq_pkg::STATUS_EMPTY))
            |-> ((rsp.count == '0) && (rsp.value == '0)))
        else $error("empty extract reports nonzero value or count");

    a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status == bmhpq_pkg::STATUS_FULL))
            |-> ((rsp.count == FULL_COUNT) && (rsp.value == '0)))
        else $error("refused insert with heap not full");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
        else $error("stalled response changed");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready) |=> !cmd_ready)
        else $error("request taken while busy");

endmodule

bind binary_max_heap_priority_queue_unit bmhpq_chk u_bmhpq_chk (.*);
